// File: rtl/lzpc_pkg.sv
package lzpc_pkg;

    localparam int BUFFER_DEPTH = 131072;
    localparam int TEXT_AW      = $clog2(BUFFER_DEPTH);
    localparam int ENTRY_AW     = $clog2(BUFFER_DEPTH + 1);
    localparam logic [18:0] DEPTH_EXT = 19'(BUFFER_DEPTH);
    localparam logic [31:0] COST_MAX  = 32'hFFFF_FFFF;

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_INIT  = 3'd1;
    localparam logic [2:0] OP_LIT   = 3'd2;
    localparam logic [2:0] OP_MATCH = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [2:0] REG_DATA_LENGTH = 3'd0;
    localparam logic [2:0] REG_MAX_MATCH   = 3'd1;
    localparam logic [2:0] REG_MIN_MATCH   = 3'd2;
    localparam logic [2:0] REG_GOOD_MATCH  = 3'd3;
    localparam logic [2:0] REG_ASCII_MODE  = 3'd4;

    typedef struct packed {
        logic [31:0] cost;
        logic [7:0]  run;
        logic [7:0]  len;
        logic [16:0] off;
        logic [16:0] rep;
        logic        flag;
    } entry_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic        after_literal;
        logic [7:0]  literal_run;
        logic [16:0] repeat_offset;
        logic [16:0] step_offset;
        logic [7:0]  step_length;
        logic [7:0]  skip_hint;
        logic [31:0] cost_value;
    } result_t;

    function automatic logic [4:0] offset_bits(input logic [16:0] off);
        logic [4:0] b;
        if (off == 17'd0) b = 5'd0;
        else if (off < 17'd128) b = 5'd8;
        else if (off < 17'd256) b = 5'd10;
        else if (off < 17'd512) b = 5'd11;
        else if (off < 17'd1024) b = 5'd13;
        else if (off < 17'd2048) b = 5'd14;
        else if (off < 17'd4096) b = 5'd16;
        else if (off < 17'd8192) b = 5'd17;
        else if (off < 17'd16384) b = 5'd19;
        else if (off < 17'd32768) b = 5'd20;
        else if (off < 17'd65536) b = 5'd21;
        else b = 5'd22;
        return b;
    endfunction

    function automatic logic [3:0] length_bits(input logic [7:0] len);
        logic [3:0] b;
        if (len <= 8'd1) b = 4'd1;
        else if (len < 8'd4) b = 4'd3;
        else if (len < 8'd8) b = 4'd5;
        else if (len < 8'd16) b = 4'd7;
        else if (len < 8'd32) b = 4'd9;
        else if (len < 8'd64) b = 4'd11;
        else if (len < 8'd128) b = 4'd13;
        else b = 4'd14;
        return b;
    endfunction

endpackage

// File: rtl/lz_optimal_parse_cost_relax_core.sv
// A literal or match step reads its entries, prices the step and may write its target;
// a match step may then compare text bytes against the repeat offset one by one and write
// a repeat entry, and init sweeps each entry of its range. One item is worked on at a time;
// the next is taken while the previous result still waits at the output register.
// Reset (aresetn low, synchronous) clears the control state and loads the register defaults;
// the text and entry memories are not cleared and hold nothing defined until written.
module lz_optimal_parse_cost_relax_core
    import lzpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // position, data_byte, end_position, initial_repeat_offset, match_offset, match_len
    input  logic [87:0] s_axis_tdata,
    // operation
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cost_value, skip_hint, entry_step_length, entry_offset, entry_repeat_offset,
    // entry_literal_run, entry_after_literal
    output logic [95:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DISP   = 4'd1;
    localparam logic [3:0] ST_SWEEP  = 4'd2;
    localparam logic [3:0] ST_L_CAP  = 4'd3;
    localparam logic [3:0] ST_L_CALC = 4'd4;
    localparam logic [3:0] ST_L_WR   = 4'd5;
    localparam logic [3:0] ST_M_CAP  = 4'd6;
    localparam logic [3:0] ST_M_EVAL = 4'd7;
    localparam logic [3:0] ST_M_WR   = 4'd8;
    localparam logic [3:0] ST_W_RD   = 4'd9;
    localparam logic [3:0] ST_W_CMP  = 4'd10;
    localparam logic [3:0] ST_W_END  = 4'd11;
    localparam logic [3:0] ST_R_WR   = 4'd12;
    localparam logic [3:0] ST_RD_OUT = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;

    logic [3:0]  state_reg, state_next;
    logic [17:0] dlen_reg, dlen_next;
    logic [7:0]  maxm_reg, maxm_next, minm_reg, minm_next, good_reg, good_next;
    logic        ascii_reg, ascii_next;

    logic [2:0]  op_reg, op_next;
    logic [17:0] pos_reg, pos_next, end_reg, end_next;
    logic [7:0]  byte_reg, byte_next, mlen_reg, mlen_next;
    logic [16:0] irep_reg, irep_next, moff_reg, moff_next;

    entry_t      src_reg, src_next;
    logic [31:0] tgt_cost_reg, tgt_cost_next, cost_reg, cost_next;
    logic [7:0]  cur_byte_reg, cur_byte_next;
    logic [7:0]  runs_reg, runs_next;
    logic [16:0] off_reg, off_next, newrep_reg, newrep_next;
    logic        evalid_reg, evalid_next, rtry_reg, rtry_next;
    logic [7:0]  n_reg, n_next, cnt_reg, cnt_next;
    logic [18:0] idx_reg, idx_next, last_reg, last_next;
    logic        swp_v_reg, swp_v_next;
    logic [ENTRY_AW-1:0] swp_a_reg, swp_a_next;

    result_t     res_reg, res_next, out_reg, out_next;
    logic        mval_reg, mval_next;

    logic                ent_we, txt_we;
    logic [ENTRY_AW-1:0] ent_waddr, ent_ra, ent_rb;
    entry_t              ent_wdata, ent_rd_a, ent_rd_b;
    logic [TEXT_AW-1:0]  txt_waddr, txt_ra, txt_rb;
    logic [7:0]          txt_rd_a, txt_rd_b;

    logic [18:0] pos_ext, tgt_ext, room;
    logic        in_text, in_entry, tag;
    logic        lit_hit;
    logic [7:0]  lit_runs;
    logic signed [34:0] lit_c;
    logic [31:0] lit_cost;
    logic        m_hit;
    logic [7:0]  elen, walk_n, n_room;
    logic [16:0] eoff;
    logic [32:0] esum, rsum;
    logic signed [19:0] diff;
    logic        accept;

    lzpc_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_text (
        .aclk    (aclk),
        .we      (txt_we),
        .waddr   (txt_waddr),
        .wdata   (byte_reg),
        .raddr_a (txt_ra),
        .rdata_a (txt_rd_a),
        .raddr_b (txt_rb),
        .rdata_b (txt_rd_b)
    );

    lzpc_ram #(.WIDTH($bits(entry_t)), .DEPTH(BUFFER_DEPTH + 1)) u_entry (
        .aclk    (aclk),
        .we      (ent_we),
        .waddr   (ent_waddr),
        .wdata   (ent_wdata),
        .raddr_a (ent_ra),
        .rdata_a (ent_rd_a),
        .raddr_b (ent_rb),
        .rdata_b (ent_rd_b)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = out_reg;
    assign cfg_ready     = 1'b1;

    assign pos_ext  = {1'b0, pos_reg};
    assign in_text  = pos_ext < DEPTH_EXT;
    assign in_entry = pos_ext <= DEPTH_EXT;
    assign tag      = !ascii_reg || !src_reg.flag;

    // Literal step pricing.
    assign lit_hit  = (src_reg.rep != 17'd0) && (pos_ext >= {2'b0, src_reg.rep})
                      && (txt_rd_b == cur_byte_reg);
    assign lit_runs = lit_hit ? 8'd1 : ((src_reg.run != 8'hFF) ? src_reg.run + 8'd1 : 8'hFF);
    always_comb begin
        lit_c = $signed({3'b0, src_reg.cost});
        if (!lit_hit) begin
            if (src_reg.run != 8'd0) begin
                lit_c = lit_c - $signed({31'b0, length_bits(src_reg.run)});
            end
            lit_c = lit_c + 35'sd8;
        end
        lit_c = lit_c + $signed({34'b0, tag}) + $signed({31'b0, length_bits(lit_runs)});
    end
    assign lit_cost = (lit_c < 0) ? 32'd0
                    : ((lit_c > $signed({3'b0, COST_MAX})) ? COST_MAX : lit_c[31:0]);

    // Match step pricing and repeat walk bound.
    assign m_hit   = (src_reg.rep != 17'd0) && (moff_reg == src_reg.rep);
    assign eoff    = m_hit ? 17'd0 : moff_reg;
    assign elen    = m_hit ? mlen_reg : ((mlen_reg != 8'd0) ? mlen_reg - 8'd1 : 8'd0);
    assign tgt_ext = pos_ext + {11'b0, mlen_reg};
    assign esum    = {1'b0, src_reg.cost} + {32'b0, tag} + {28'b0, offset_bits(eoff)}
                   + {29'b0, length_bits(elen)};
    assign diff    = $signed({2'b0, dlen_reg}) - $signed({2'b0, pos_reg});
    assign walk_n  = (diff > $signed({12'b0, maxm_reg})) ? maxm_reg
                   : ((diff < 0) ? 8'd0 : diff[7:0]);
    assign room    = DEPTH_EXT - pos_ext;
    assign n_room  = ({11'b0, walk_n} > room) ? room[7:0] : walk_n;
    assign rsum    = {1'b0, src_reg.cost} + {32'b0, tag} + {29'b0, length_bits(cnt_reg)};

    always_comb begin
        state_next    = state_reg;
        dlen_next     = dlen_reg;
        maxm_next     = maxm_reg;
        minm_next     = minm_reg;
        good_next     = good_reg;
        ascii_next    = ascii_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        end_next      = end_reg;
        byte_next     = byte_reg;
        mlen_next     = mlen_reg;
        irep_next     = irep_reg;
        moff_next     = moff_reg;
        src_next      = src_reg;
        tgt_cost_next = tgt_cost_reg;
        cost_next     = cost_reg;
        cur_byte_next = cur_byte_reg;
        runs_next     = runs_reg;
        off_next      = off_reg;
        newrep_next   = newrep_reg;
        evalid_next   = evalid_reg;
        rtry_next     = rtry_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        swp_v_next    = 1'b0;
        swp_a_next    = swp_a_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        mval_next     = mval_reg && !m_axis_tready;

        ent_we    = 1'b0;
        ent_waddr = pos_reg[ENTRY_AW-1:0];
        ent_wdata = '0;
        ent_ra    = pos_reg[ENTRY_AW-1:0];
        ent_rb    = pos_reg[ENTRY_AW-1:0];
        txt_we    = 1'b0;
        txt_waddr = pos_reg[TEXT_AW-1:0];
        txt_ra    = pos_reg[TEXT_AW-1:0];
        txt_rb    = pos_reg[TEXT_AW-1:0];

        if (cfg_valid) begin
            case (cfg_index)
                REG_DATA_LENGTH: dlen_next  = cfg_data;
                REG_MAX_MATCH:   maxm_next  = cfg_data[7:0];
                REG_MIN_MATCH:   minm_next  = cfg_data[7:0];
                REG_GOOD_MATCH:  good_next  = cfg_data[7:0];
                REG_ASCII_MODE:  ascii_next = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = s_axis_tuser;
                    pos_next   = s_axis_tdata[17:0];
                    byte_next  = s_axis_tdata[25:18];
                    end_next   = s_axis_tdata[43:26];
                    irep_next  = s_axis_tdata[60:44];
                    moff_next  = s_axis_tdata[77:61];
                    mlen_next  = s_axis_tdata[85:78];
                    res_next   = '0;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                state_next = ST_DONE;
                unique case (op_reg)
                    OP_LOAD: begin
                        txt_we = in_text;
                    end
                    OP_INIT: begin
                        ent_we         = in_entry;
                        ent_wdata      = '0;
                        ent_wdata.rep  = irep_reg;
                        idx_next       = pos_ext + 19'd1;
                        last_next      = ({1'b0, end_reg} > DEPTH_EXT) ? DEPTH_EXT
                                                                       : {1'b0, end_reg};
                        state_next     = ST_SWEEP;
                    end
                    OP_LIT: begin
                        ent_rb = ENTRY_AW'(pos_ext + 19'd1);
                        if (in_text) begin
                            state_next = ST_L_CAP;
                        end
                    end
                    OP_MATCH: begin
                        ent_rb = tgt_ext[ENTRY_AW-1:0];
                        if (in_text) begin
                            state_next = ST_M_CAP;
                        end else begin
                            res_next.skip_hint = 8'd1;
                        end
                    end
                    OP_READ: begin
                        if (in_entry) begin
                            state_next = ST_RD_OUT;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SWEEP: begin
                ent_ra = idx_reg[ENTRY_AW-1:0];
                if (idx_reg <= last_reg) begin
                    swp_v_next = 1'b1;
                    swp_a_next = idx_reg[ENTRY_AW-1:0];
                    idx_next   = idx_reg + 19'd1;
                end else if (!swp_v_reg) begin
                    state_next = ST_DONE;
                end
                if (swp_v_reg) begin
                    ent_we         = 1'b1;
                    ent_waddr      = swp_a_reg;
                    ent_wdata      = ent_rd_a;
                    ent_wdata.cost = COST_MAX;
                    ent_wdata.run  = 8'd0;
                end
            end
            ST_L_CAP: begin
                src_next      = ent_rd_a;
                tgt_cost_next = ent_rd_b.cost;
                cur_byte_next = txt_rd_a;
                txt_rb        = TEXT_AW'(pos_ext - {2'b0, ent_rd_a.rep});
                state_next    = ST_L_CALC;
            end
            ST_L_CALC: begin
                cost_next  = lit_cost;
                runs_next  = lit_runs;
                off_next   = lit_hit ? src_reg.rep : 17'd0;
                state_next = ST_L_WR;
            end
            ST_L_WR: begin
                ent_waddr           = ENTRY_AW'(pos_ext + 19'd1);
                ent_we              = tgt_cost_reg >= cost_reg;
                ent_wdata.cost      = cost_reg;
                ent_wdata.run       = (off_reg == 17'd0) ? runs_reg : 8'd0;
                ent_wdata.len       = 8'd1;
                ent_wdata.off       = off_reg;
                ent_wdata.rep       = src_reg.rep;
                ent_wdata.flag      = off_reg == 17'd0;
                res_next.cost_value = cost_reg;
                state_next          = ST_DONE;
            end
            ST_M_CAP: begin
                src_next      = ent_rd_a;
                tgt_cost_next = ent_rd_b.cost;
                state_next    = ST_M_EVAL;
            end
            ST_M_EVAL: begin
                cost_next   = esum[32] ? COST_MAX : esum[31:0];
                off_next    = eoff;
                newrep_next = m_hit ? src_reg.rep : moff_reg;
                evalid_next = (moff_reg != 17'd0) && (elen != 8'd0) && (tgt_ext <= DEPTH_EXT);
                rtry_next   = !m_hit && (src_reg.rep != 17'd0)
                              && (pos_ext >= {2'b0, src_reg.rep});
                n_next      = n_room;
                cnt_next    = 8'd0;
                state_next  = ST_M_WR;
            end
            ST_M_WR: begin
                ent_waddr      = tgt_ext[ENTRY_AW-1:0];
                ent_we         = evalid_reg && (tgt_cost_reg >= cost_reg);
                ent_wdata.cost = cost_reg;
                ent_wdata.len  = mlen_reg;
                ent_wdata.off  = off_reg;
                ent_wdata.rep  = newrep_reg;
                if (rtry_reg) begin
                    state_next = ST_W_RD;
                end else begin
                    res_next.skip_hint = (mlen_reg >= good_reg) ? good_reg : 8'd1;
                    state_next         = ST_DONE;
                end
            end
            ST_W_RD: begin
                txt_ra = TEXT_AW'(pos_ext + {11'b0, cnt_reg});
                txt_rb = TEXT_AW'(pos_ext - {2'b0, src_reg.rep} + {11'b0, cnt_reg});
                state_next = (cnt_reg < n_reg) ? ST_W_CMP : ST_W_END;
            end
            ST_W_CMP: begin
                if (txt_rd_a == txt_rd_b) begin
                    cnt_next   = cnt_reg + 8'd1;
                    state_next = ST_W_RD;
                end else begin
                    state_next = ST_W_END;
                end
            end
            ST_W_END: begin
                ent_rb             = ENTRY_AW'(pos_ext + {11'b0, cnt_reg});
                cost_next          = rsum[32] ? COST_MAX : rsum[31:0];
                res_next.skip_hint = (cnt_reg >= good_reg) ? good_reg : 8'd1;
                state_next = ((cnt_reg != 8'd0) && (cnt_reg >= minm_reg)) ? ST_R_WR : ST_DONE;
            end
            ST_R_WR: begin
                ent_waddr      = ENTRY_AW'(pos_ext + {11'b0, cnt_reg});
                ent_we         = ent_rd_b.cost >= cost_reg;
                ent_wdata.cost = cost_reg;
                ent_wdata.len  = cnt_reg;
                ent_wdata.rep  = src_reg.rep;
                state_next     = ST_DONE;
            end
            ST_RD_OUT: begin
                res_next.cost_value    = ent_rd_a.cost;
                res_next.step_length   = ent_rd_a.len;
                res_next.step_offset   = ent_rd_a.off;
                res_next.repeat_offset = ent_rd_a.rep;
                res_next.literal_run   = ent_rd_a.run;
                res_next.after_literal = ent_rd_a.flag;
                state_next             = ST_DONE;
            end
            ST_DONE: begin
                if (!mval_reg || m_axis_tready) begin
                    out_next   = res_reg;
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mval_reg  <= 1'b0;
            swp_v_reg <= 1'b0;
            dlen_reg  <= 18'd131072;
            maxm_reg  <= 8'd255;
            minm_reg  <= 8'd2;
            good_reg  <= 8'd255;
            ascii_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
            swp_v_reg <= swp_v_next;
            dlen_reg  <= dlen_next;
            maxm_reg  <= maxm_next;
            minm_reg  <= minm_next;
            good_reg  <= good_next;
            ascii_reg <= ascii_next;
        end
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        end_reg      <= end_next;
        byte_reg     <= byte_next;
        mlen_reg     <= mlen_next;
        irep_reg     <= irep_next;
        moff_reg     <= moff_next;
        src_reg      <= src_next;
        tgt_cost_reg <= tgt_cost_next;
        cost_reg     <= cost_next;
        cur_byte_reg <= cur_byte_next;
        runs_reg     <= runs_next;
        off_reg      <= off_next;
        newrep_reg   <= newrep_next;
        evalid_reg   <= evalid_next;
        rtry_reg     <= rtry_next;
        n_reg        <= n_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        swp_a_reg    <= swp_a_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule

// File: rtl/lzpc_ram.sv
module lzpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/lzpc_checker.sv
module lzpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [87:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [17:0] cfg_data
);

    // The block takes one word at a time, so acceptance closes the input side.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // A new result only appears while an item is being worked on.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result raised while idle");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind lz_optimal_parse_cost_relax_core lzpc_checker u_lzpc_checker (.*);

// File: tb/sv/tb_lz_optimal_parse_cost_relax_core.sv
module tb_lz_optimal_parse_cost_relax_core;
    import lzpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REGION = 320;
    localparam int MATCH_LAST = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [17:0] pos;
        logic [7:0]  dbyte;
        logic [17:0] endp;
        logic [16:0] irep;
        logic [16:0] moff;
        logic [7:0]  mlen;
    } parse_item_t;

    class relax_scoreboard;
        bit [7:0]  text_mem[int];
        bit [31:0] cost_mem[int];
        bit [7:0]  len_mem[int];
        bit [16:0] off_mem[int];
        bit [16:0] rep_mem[int];
        bit [7:0]  run_mem[int];
        bit        lit_mem[int];
        bit [1:0]  known[int];
        bit [17:0] data_len = 18'd131072;
        bit [7:0]  longest = 8'd255;
        bit [7:0]  shortest = 8'd2;
        bit [7:0]  good_len = 8'd255;
        bit        ascii = 1'b0;
        result_t   due_words[$];
        int        errors = 0;

        function int offset_price(int off);
            int b;
            b = (off == 0) ? 0 : (off < 128) ? 8 : (off < 256) ? 10 : (off < 512) ? 11 :
                (off < 1024) ? 13 : (off < 2048) ? 14 : (off < 4096) ? 16 :
                (off < 8192) ? 17 : (off < 16384) ? 19 : (off < 32768) ? 20 :
                (off < 65536) ? 21 : 22;
            return b;
        endfunction

        function int length_price(int len);
            int b;
            b = (len <= 1) ? 1 : (len < 4) ? 3 : (len < 8) ? 5 : (len < 16) ? 7 :
                (len < 32) ? 9 : (len < 64) ? 11 : (len < 128) ? 13 : 14;
            return b;
        endfunction

        function bit [31:0] clamp(longint v);
            if (v < 0) return 32'd0;
            if (v > 64'hFFFF_FFFF) return COST_MAX;
            return v[31:0];
        endfunction

        function bit full(int p);
            return known.exists(p) && known[p] == 2'b11;
        endfunction

        function int rep_at(int p);
            return rep_mem[p];
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void configure(logic [2:0] idx, logic [17:0] v);
            case (idx)
                REG_DATA_LENGTH: data_len = v;
                REG_MAX_MATCH:   longest = v[7:0];
                REG_MIN_MATCH:   shortest = v[7:0];
                REG_GOOD_MATCH:  good_len = v[7:0];
                REG_ASCII_MODE:  ascii = v[0];
                default: ;
            endcase
        endfunction

        function void write_entry(int t, bit [31:0] c, int len, int off, int rep, int run,
                                  bit lit);
            cost_mem[t] = c;
            len_mem[t] = len;
            off_mem[t] = off;
            rep_mem[t] = rep;
            run_mem[t] = run;
            lit_mem[t] = lit;
            known[t] = 2'b11;
        endfunction

        function void note(parse_item_t it);
            result_t r;
            int p, rep, runs, off, tag, eoff, elen, newrep, fin, cnt, last;
            longint c, lim, n;
            bit hit;
            r = '0;
            p = it.pos;
            case (it.op)
                OP_LOAD: if (p < BUFFER_DEPTH) text_mem[p] = it.dbyte;
                OP_INIT: begin
                    last = (it.endp > BUFFER_DEPTH) ? BUFFER_DEPTH : it.endp;
                    if (p <= BUFFER_DEPTH)
                        write_entry(p, 0, 0, 0, it.irep, 0, 0);
                    for (int k = p + 1; k <= last; k++) begin
                        cost_mem[k] = COST_MAX;
                        run_mem[k] = 0;
                        known[k] = known.exists(k) ? (known[k] | 2'b01) : 2'b01;
                    end
                end
                OP_LIT: if (p < BUFFER_DEPTH) begin
                    rep = rep_mem[p];
                    runs = run_mem[p];
                    c = cost_mem[p];
                    if (rep != 0 && p >= rep && text_mem[p - rep] == text_mem[p]) begin
                        off = rep;
                        runs = 1;
                    end else begin
                        if (runs > 0) c -= length_price(runs);
                        if (runs < 255) runs++;
                        c += 8;
                        off = 0;
                    end
                    if (!ascii || !lit_mem[p]) c += 1;
                    c += length_price(runs);
                    r.cost_value = clamp(c);
                    if (cost_mem[p + 1] >= r.cost_value)
                        write_entry(p + 1, r.cost_value, 1, off, rep,
                                    (off == 0) ? runs : 0, off == 0);
                end
                OP_MATCH: begin
                    r.skip_hint = 8'd1;
                    if (p < BUFFER_DEPTH) begin
                        rep = rep_mem[p];
                        tag = (!ascii || !lit_mem[p]) ? 1 : 0;
                        hit = rep != 0 && it.moff == rep;
                        eoff = hit ? 0 : it.moff;
                        elen = hit ? it.mlen : ((it.mlen > 0) ? it.mlen - 1 : 0);
                        newrep = hit ? rep : it.moff;
                        if (it.moff != 0 && elen >= 1 && p + it.mlen <= BUFFER_DEPTH) begin
                            c = longint'(cost_mem[p]) + tag + offset_price(eoff)
                                + length_price(elen);
                            if (cost_mem[p + it.mlen] >= clamp(c))
                                write_entry(p + it.mlen, clamp(c), it.mlen, eoff, newrep,
                                            0, 0);
                        end
                        fin = it.mlen;
                        if (!hit && rep != 0 && p >= rep) begin
                            lim = longint'(data_len) - longint'(longest);
                            n = (p < lim) ? longint'(longest) : longint'(data_len) - p;
                            if (n < 0) n = 0;
                            if (n > BUFFER_DEPTH - p) n = BUFFER_DEPTH - p;
                            cnt = 0;
                            while (cnt < n && text_mem[p + cnt] == text_mem[p - rep + cnt])
                                cnt++;
                            fin = cnt;
                            if (fin >= 1 && fin >= shortest) begin
                                c = longint'(cost_mem[p]) + tag + length_price(fin);
                                if (cost_mem[p + fin] >= clamp(c))
                                    write_entry(p + fin, clamp(c), fin, 0, rep, 0, 0);
                            end
                        end
                        r.skip_hint = (fin >= good_len) ? good_len : 8'd1;
                    end
                end
                OP_READ: if (p <= BUFFER_DEPTH) begin
                    r.cost_value = cost_mem[p];
                    r.step_length = len_mem[p];
                    r.step_offset = off_mem[p];
                    r.repeat_offset = rep_mem[p];
                    r.literal_run = run_mem[p];
                    r.after_literal = lit_mem[p];
                end
                default: ;
            endcase
            due_words.push_back(r);
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
            errors++;
        endtask

        task check(result_t got);
            result_t want;
            if (due_words.size() == 0) begin
                report("unexpected word", 0, got.cost_value);
                return;
            end
            want = due_words.pop_front();
            if (got.cost_value !== want.cost_value)
                report("cost_value", want.cost_value, got.cost_value);
            if (got.skip_hint !== want.skip_hint)
                report("skip_hint", want.skip_hint, got.skip_hint);
            if (got.step_length !== want.step_length)
                report("entry_step_length", want.step_length, got.step_length);
            if (got.step_offset !== want.step_offset)
                report("entry_offset", want.step_offset, got.step_offset);
            if (got.repeat_offset !== want.repeat_offset)
                report("entry_repeat_offset", want.repeat_offset, got.repeat_offset);
            if (got.literal_run !== want.literal_run)
                report("entry_literal_run", want.literal_run, got.literal_run);
            if (got.after_literal !== want.after_literal)
                report("entry_after_literal", want.after_literal, got.after_literal);
            if (got.pad !== 5'd0)
                report("padding", 0, got.pad);
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [17:0] cfg_data;

    relax_scoreboard board;
    int  burst_left;
    int  cycles;
    bit  hold_req;

    lz_optimal_parse_cost_relax_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_lz_optimal_parse_cost_relax_core: errors");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check(result_t'(m_axis_tdata));

    // The receiver's ready is always, mostly or seldom high, or held low on hold_req.
    initial begin
        int mode, left;
        m_axis_tready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                    default: m_axis_tready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    task send(parse_item_t it);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tdata <= {2'b00, it.mlen, it.moff, it.irep, it.endp, it.dbyte, it.pos};
        s_axis_tuser <= it.op;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note(it);
        @(negedge aclk);
        burst_left--;
    endtask

    task go(logic [2:0] op, int pos, int dbyte = 0, int endp = 0, int irep = 0,
            int moff = 0, int mlen = 0);
        parse_item_t it;
        it.op = op;
        it.pos = pos;
        it.dbyte = dbyte;
        it.endp = endp;
        it.irep = irep;
        it.moff = moff;
        it.mlen = mlen;
        send(it);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task write_reg(logic [2:0] idx, int v);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.configure(idx, v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task set_regs(int dl, int mx, int mn, int good, int asc);
        drain();
        repeat (8) @(negedge aclk);
        write_reg(REG_DATA_LENGTH, dl);
        write_reg(REG_MAX_MATCH, mx);
        write_reg(REG_MIN_MATCH, mn);
        write_reg(REG_GOOD_MATCH, good);
        write_reg(REG_ASCII_MODE, asc);
    endtask

    task run_phase(int count, bit chain);
        int done, p, q, k, rep, moff, top;
        done = 0;
        if (chain) begin
            go(OP_INIT, 0, 0, REGION - 1, 0);
            for (p = 0; p < 300; p++) go(OP_LIT, p);
            go(OP_READ, 300);
        end
        while (done < count) begin
            p = $urandom_range(0, 4);
            case ($urandom_range(0, 3))
                0: rep = 0;
                1: rep = $urandom_range(1, 131071);
                default: rep = $urandom_range(1, 8);
            endcase
            go(OP_INIT, p, 0, REGION - 1, rep);
            done++;
            while (done < count && p < REGION - 1) begin
                k = $urandom_range(0, 99);
                done++;
                if (done == count / 3) drain();
                if (k < 8) begin
                    q = $urandom_range(0, REGION - 1);
                    go(OP_READ, board.full(q) ? q : p);
                    continue;
                end else if (k < 13) begin
                    go(OP_LOAD, $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                           : $urandom_range(0, REGION - 1),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 2));
                    continue;
                end else if (k < 16) begin
                    case ($urandom_range(0, 4))
                        0: go(OP_LIT, $urandom_range(BUFFER_DEPTH, 262143));
                        1: go(OP_MATCH, $urandom_range(BUFFER_DEPTH, 262143), 0, 0, 0,
                              $urandom_range(1, 131071), $urandom_range(1, 255));
                        2: go(OP_READ, $urandom_range(BUFFER_DEPTH + 1, 262143));
                        3: go(OP_LOAD, $urandom_range(BUFFER_DEPTH, 262143),
                              $urandom_range(0, 255));
                        default: go($urandom_range(OP_SPARE_LO, OP_SPARE_HI),
                                    $urandom_range(0, 262143), $urandom_range(0, 255),
                                    $urandom_range(0, 262143), $urandom_range(0, 131071),
                                    $urandom_range(0, 131071), $urandom_range(0, 255));
                    endcase
                    continue;
                end else if (k < 55 || p > MATCH_LAST) begin
                    go(OP_LIT, p);
                end else begin
                    rep = board.rep_at(p);
                    if (rep != 0 && $urandom_range(0, 2) == 0) moff = rep;
                    else if ($urandom_range(0, 3) == 0) moff = $urandom_range(1, 131071);
                    else moff = $urandom_range(1, 8);
                    top = REGION - 1 - p;
                    if (top > 255) top = 255;
                    go(OP_MATCH, p, 0, 0, 0, moff,
                       $urandom_range(0, 7) == 0 ? $urandom_range(1, top)
                                                 : $urandom_range(1, 16));
                end
                q = p + 1;
                while (q < REGION - 1 && !board.full(q)) q++;
                p = q;
                if (!board.full(p)) break;
            end
        end
    endtask

    initial begin
        board = new();
        cycles = 0;
        hold_req = 1'b0;
        burst_left = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOAD;
        cfg_valid = 1'b0;
        cfg_index = REG_DATA_LENGTH;
        cfg_data = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < REGION; i++)
            go(OP_LOAD, i, (i % 37 == 5) ? 255 :
                           (i >= 100 && i < 200) ? i % 3 : $urandom_range(0, 2));
        go(OP_LOAD, 131071, 255);
        go(OP_LOAD, BUFFER_DEPTH, 8'h5A);
        go(OP_LOAD, 262143, 0);
        go(OP_INIT, BUFFER_DEPTH, 0, BUFFER_DEPTH, 131071);
        go(OP_READ, BUFFER_DEPTH);
        go(OP_READ, BUFFER_DEPTH + 1);
        go(OP_READ, 262143);
        go(OP_INIT, 131000, 0, 262143, 5);
        go(OP_LIT, BUFFER_DEPTH);
        go(OP_MATCH, BUFFER_DEPTH, 0, 0, 0, 5, 4);
        go(OP_MATCH, 262143, 0, 0, 0, 131071, 255);
        go(OP_INIT, 0, 0, REGION - 1, 3);
        for (int i = 0; i < 5; i++) go(OP_LIT, i);
        go(OP_MATCH, 4, 0, 0, 0, 3, 6);
        go(OP_MATCH, 4, 0, 0, 0, 0, 0);
        go(OP_MATCH, 4, 0, 0, 0, 1, 1);
        go(OP_MATCH, 4, 0, 0, 0, 131071, 255);
        go(OP_MATCH, 5, 0, 0, 0, 7, 2);
        go(OP_READ, 5);
        go(OP_READ, 259);
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            go(op, 262143, 255, 262143, 131071, 131071, 255);

        run_phase(100, 1'b0);
        set_regs(REGION, 255, 1, 1, 1);
        hold_req = 1'b1;
        run_phase(150, 1'b1);
        set_regs(0, 1, 255, 255, 0);
        run_phase(120, 1'b0);
        set_regs(BUFFER_DEPTH, 16, 3, 8, 1);
        run_phase(150, 1'b1);
        set_regs(100, 200, 2, 4, 0);
        run_phase(150, 1'b0);

        drain();
        repeat (20) @(posedge aclk);
        if (board.errors == 0)
            $display("tb_lz_optimal_parse_cost_relax_core: clean");
        else
            $display("tb_lz_optimal_parse_cost_relax_core: errors");
        $finish;
    end

endmodule
